### hdl/tuc_pkg.sv
// ----------------------------------------------------------------------------
// tuc_pkg
// Shared types and constants of the tile uniformity classifier.
// ----------------------------------------------------------------------------
package tuc_pkg;

    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int PIX_W        = 8;
    localparam int TILE_FIELD_W = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [PIX_W-1:0] PIX_FULL     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_START,
        S_SETUP,
        S_AREA,
        S_SCALE,
        S_RUN
    } t_setup_state;

    // Per-pixel flags handed from the front to the back.
    typedef struct packed {
        logic white;
        logic tile_end;
        logic last;
    } t_pix_flags;

endpackage

### hdl/tuc_fifo.sv
// ----------------------------------------------------------------------------
// tuc_fifo
// Small register-based first-in first-out queue with a synchronous clear.
// ----------------------------------------------------------------------------
module tuc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [WIDTH-1:0]             o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
        if (i_clear) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill level exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("beat pushed into a full queue");

endmodule

### hdl/tuc_dim_setup.sv
// ----------------------------------------------------------------------------
// tuc_dim_setup
// Derives the tile size of one image dimension by a reciprocal multiply with
// the grid size, then the number of judged tiles from the remainder.
// ----------------------------------------------------------------------------
module tuc_dim_setup #(
    parameter int GRID_TILES = 10,
    parameter int MAX_DIM    = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [$clog2(MAX_DIM+1)-1:0]        i_dim,
    output logic                                o_done,
    output logic [$clog2(MAX_DIM/GRID_TILES+1)-1:0] o_tile,
    output logic [$clog2(GRID_TILES+1)-1:0]     o_count
);
    localparam int DIM_W   = $clog2(MAX_DIM+1);
    localparam int TS_W    = $clog2(MAX_DIM/GRID_TILES+1);
    localparam int TI_W    = $clog2(GRID_TILES+1);
    // Rounded-up reciprocal; the quotient is exact for every dimension below
    // 2**DIM_W.
    localparam int SHIFT   = DIM_W + $clog2(GRID_TILES);
    localparam int RECIP   = (2**SHIFT + GRID_TILES - 1) / GRID_TILES;
    localparam int RECIP_W = $clog2(RECIP+1);
    localparam int PROD_W  = DIM_W + RECIP_W;

    logic              r_busy, n_busy;
    logic              r_step, n_step;
    logic [DIM_W-1:0]  r_dim;
    logic [TS_W-1:0]   r_tile, n_tile;
    logic [TI_W-1:0]   r_k, n_k;

    logic [PROD_W-1:0] w_prod;
    logic [DIM_W-1:0]  w_back;
    logic              w_exact;

    assign o_done  = !r_busy;
    assign o_tile  = r_tile;
    assign o_count = r_k;

    assign w_prod  = {{RECIP_W{1'b0}}, r_dim} * PROD_W'(RECIP);
    assign w_back  = {{(DIM_W-TS_W){1'b0}}, r_tile} * DIM_W'(GRID_TILES);
    assign w_exact = (w_back == r_dim);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_tile = r_tile;
        n_k    = r_k;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 1'b0;
        end else if (r_busy) begin
            if (!r_step) begin
                n_tile = w_prod[SHIFT +: TS_W];
                n_step = 1'b1;
            end else begin
                // With dim = grid * tile + rem, (dim - 1) / tile is one short of
                // the grid when rem is zero and reaches the grid otherwise.
                if (r_tile == '0) begin
                    n_k = '0;
                end else if (w_exact) begin
                    n_k = TI_W'(GRID_TILES - 1);
                end else begin
                    n_k = TI_W'(GRID_TILES);
                end
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_tile <= '0;
            r_k    <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_tile <= n_tile;
            r_k    <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dim <= i_dim;
        end
    end

endmodule

### hdl/tuc_front.sv
// ----------------------------------------------------------------------------
// tuc_front
// Tracks the raster position of each accepted pixel, places it in the tile
// grid and forwards pixels of judged tiles with their flags.
// ----------------------------------------------------------------------------
module tuc_front #(
    parameter int GRID_TILES = 10,
    parameter int MAX_DIM    = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_clear,
    input  logic                                    i_accept,
    input  logic [tuc_pkg::PIX_W-1:0]               i_red,
    input  logic [tuc_pkg::PIX_W-1:0]               i_green,
    input  logic [tuc_pkg::PIX_W-1:0]               i_blue,
    input  logic [$clog2(MAX_DIM+1)-1:0]            i_width,
    input  logic [$clog2(MAX_DIM+1)-1:0]            i_height,
    input  logic [$clog2(MAX_DIM/GRID_TILES+1)-1:0] i_tile_w,
    input  logic [$clog2(MAX_DIM/GRID_TILES+1)-1:0] i_tile_h,
    input  logic [$clog2(GRID_TILES+1)-1:0]         i_ncol,
    input  logic [$clog2(GRID_TILES+1)-1:0]         i_nrow,
    output logic                                    o_push,
    output logic [$clog2(GRID_TILES)-1:0]           o_tx,
    output logic [$clog2(GRID_TILES)-1:0]           o_ty,
    output tuc_pkg::t_pix_flags                     o_flags
);
    import tuc_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int TS_W  = $clog2(MAX_DIM/GRID_TILES+1);
    localparam int TI_W  = $clog2(GRID_TILES+1);
    localparam int IDX_W = $clog2(GRID_TILES);

    logic [DIM_W-1:0] r_x, n_x;
    logic [DIM_W-1:0] r_y, n_y;
    logic [TS_W-1:0]  r_lx, n_lx;
    logic [TS_W-1:0]  r_ly, n_ly;
    logic [TI_W-1:0]  r_tx, n_tx;
    logic [TI_W-1:0]  r_ty, n_ty;

    logic w_end_x;
    logic w_end_y;
    logic w_judged;
    logic w_line_end;
    logic w_frame_end;

    assign w_end_x     = (r_lx == i_tile_w - 1'b1);
    assign w_end_y     = (r_ly == i_tile_h - 1'b1);
    assign w_judged    = (r_tx < i_ncol) && (r_ty < i_nrow);
    assign w_line_end  = ({1'b0, r_x} + 1'b1) >= {1'b0, i_width};
    assign w_frame_end = ({1'b0, r_y} + 1'b1) >= {1'b0, i_height};

    assign o_push           = i_accept && w_judged;
    assign o_tx             = r_tx[IDX_W-1:0];
    assign o_ty             = r_ty[IDX_W-1:0];
    assign o_flags.white    = (i_red == PIX_FULL) && (i_green == PIX_FULL)
                              && (i_blue == PIX_FULL);
    assign o_flags.tile_end = w_end_x && w_end_y;
    assign o_flags.last     = (r_tx == i_ncol - 1'b1) && (r_ty == i_nrow - 1'b1);

    always_comb begin
        n_x  = r_x;
        n_y  = r_y;
        n_lx = r_lx;
        n_ly = r_ly;
        n_tx = r_tx;
        n_ty = r_ty;
        if (i_accept) begin
            if (w_line_end) begin
                n_x  = '0;
                n_lx = '0;
                n_tx = '0;
                if (w_frame_end) begin
                    n_y  = '0;
                    n_ly = '0;
                    n_ty = '0;
                end else begin
                    n_y  = r_y + 1'b1;
                    n_ly = w_end_y ? '0 : r_ly + 1'b1;
                    // Tile indices saturate at the grid size; beyond it nothing is judged.
                    if (w_end_y && 32'(r_ty) < 32'(GRID_TILES)) begin
                        n_ty = r_ty + 1'b1;
                    end
                end
            end else begin
                n_x  = r_x + 1'b1;
                n_lx = w_end_x ? '0 : r_lx + 1'b1;
                if (w_end_x && 32'(r_tx) < 32'(GRID_TILES)) begin
                    n_tx = r_tx + 1'b1;
                end
            end
        end
        if (i_clear) begin
            n_x  = '0;
            n_y  = '0;
            n_lx = '0;
            n_ly = '0;
            n_tx = '0;
            n_ty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_lx <= '0;
            r_ly <= '0;
            r_tx <= '0;
            r_ty <= '0;
        end else begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_lx <= n_lx;
            r_ly <= n_ly;
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
    end

endmodule

### hdl/tuc_back.sv
// ----------------------------------------------------------------------------
// tuc_back
// Accumulates white pixel counts per tile column and, at the end of each
// judged tile, grades the tile and pushes one decision beat.
// ----------------------------------------------------------------------------
module tuc_back #(
    parameter int GRID_TILES = 10,
    parameter int MAX_DIM    = 4096,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_clear,
    input  logic                                                   i_valid,
    input  logic [$clog2(GRID_TILES)-1:0]                          i_tx,
    input  logic [$clog2(GRID_TILES)-1:0]                          i_ty,
    input  tuc_pkg::t_pix_flags                                    i_flags,
    output logic                                                   o_take,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]                         i_out_count,
    input  logic [$clog2((MAX_DIM/GRID_TILES)*(MAX_DIM/GRID_TILES)+1)-1:0] i_area,
    input  logic [$clog2((MAX_DIM/GRID_TILES)*(MAX_DIM/GRID_TILES)+1)+4:0] i_area19,
    output logic                                                   o_push,
    output logic [tuc_pkg::TILE_FIELD_W-1:0]                       o_tile_row,
    output logic [tuc_pkg::TILE_FIELD_W-1:0]                       o_tile_col,
    output logic                                                   o_make_white,
    output logic                                                   o_last_tile
);
    import tuc_pkg::*;

    localparam int IDX_W  = $clog2(GRID_TILES);
    localparam int MAX_TS = MAX_DIM / GRID_TILES;
    localparam int AREA_W = $clog2(MAX_TS*MAX_TS+1);

    logic [AREA_W-1:0] r_counts [GRID_TILES];
    logic              r_s2_valid;
    logic [IDX_W-1:0]  r_s2_row;
    logic [IDX_W-1:0]  r_s2_col;
    logic [AREA_W-1:0] r_s2_wc;
    logic              r_s2_last;

    logic                          w_room;
    logic [AREA_W-1:0]             w_count_next;
    logic [AREA_W+4:0]             w_wc20;
    logic [IDX_W+TILE_FIELD_W-1:0] w_row_ext;
    logic [IDX_W+TILE_FIELD_W-1:0] w_col_ext;

    // A tile end may only enter the grading stage if its beat has a slot.
    assign w_room       = (32'(i_out_count) + 32'(r_s2_valid)) < 32'(OUT_DEPTH);
    assign o_take       = i_valid && (!i_flags.tile_end || w_room);
    assign w_count_next = r_counts[i_tx] + AREA_W'(i_flags.white);

    assign w_wc20       = {1'b0, r_s2_wc, 4'b0000} + {3'b000, r_s2_wc, 2'b00};
    assign w_row_ext    = {{TILE_FIELD_W{1'b0}}, r_s2_row};
    assign w_col_ext    = {{TILE_FIELD_W{1'b0}}, r_s2_col};

    assign o_push       = r_s2_valid;
    assign o_tile_row   = w_row_ext[TILE_FIELD_W-1:0];
    assign o_tile_col   = w_col_ext[TILE_FIELD_W-1:0];
    assign o_make_white = (w_wc20 > i_area19) || (w_wc20 <= {5'b00000, i_area});
    assign o_last_tile  = r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < GRID_TILES; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_s2_valid <= o_take && i_flags.tile_end;
            if (o_take) begin
                r_counts[i_tx] <= i_flags.tile_end ? '0 : w_count_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_flags.tile_end) begin
            r_s2_row  <= i_ty;
            r_s2_col  <= i_tx;
            r_s2_wc   <= w_count_next;
            r_s2_last <= i_flags.last;
        end
    end

    a_push_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (32'(i_out_count) < 32'(OUT_DEPTH)))
        else $error("decision beat graded with no free result slot");

    a_grade_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !$past(i_clear)) |-> $past(o_take && i_flags.tile_end))
        else $error("decision beat without a preceding tile end");

endmodule

### hdl/tile_uniformity_classifier_unit.sv
// ----------------------------------------------------------------------------
// tile_uniformity_classifier_unit
// Grades the tiles of a raster RGB image as uniform (to be filled white) or
// not, from the share of pure-white pixels in each tile.
// ----------------------------------------------------------------------------
// Pixels stream in raster order, one beat per clock while full is low; a
// decision beat passes the pixel queue, the grading register and the decision
// queue after the last pixel of a judged tile. After reset and after every
// register write the unit restarts the image and holds full high while a
// reciprocal multiply derives the tile sizes, the remainder gives the number
// of judged tiles and the tile area and its scaled bound are registered.
// Full also rises when the decision queue backs up into the pixel queue.
module tile_uniformity_classifier_unit #(
    parameter int GRID_TILES = 10,
    parameter int MAX_DIM    = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [tuc_pkg::PIX_W-1:0]             i_red,
    input  logic [tuc_pkg::PIX_W-1:0]             i_green,
    input  logic [tuc_pkg::PIX_W-1:0]             i_blue,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [tuc_pkg::TILE_FIELD_W-1:0]      o_tile_row,
    output logic [tuc_pkg::TILE_FIELD_W-1:0]      o_tile_col,
    output logic                                  o_make_white,
    output logic                                  o_last_tile,
    input  logic                                  i_cfg_we,
    input  logic [tuc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tuc_pkg::CFG_W-1:0]             i_cfg_data
);
    import tuc_pkg::*;

    localparam int DIM_W     = $clog2(MAX_DIM+1);
    localparam int MAX_TS    = MAX_DIM / GRID_TILES;
    localparam int TS_W      = $clog2(MAX_TS+1);
    localparam int TI_W      = $clog2(GRID_TILES+1);
    localparam int IDX_W     = $clog2(GRID_TILES);
    localparam int AREA_W    = $clog2(MAX_TS*MAX_TS+1);
    localparam int FLAG_W    = $bits(t_pix_flags);
    localparam int MID_W     = 2*IDX_W + FLAG_W;
    localparam int MID_DEPTH = 4;
    localparam int OUT_W     = 2*TILE_FIELD_W + 2;
    localparam int OUT_DEPTH = 3;

    logic [CFG_W-1:0]    r_cfg_width;
    logic [CFG_W-1:0]    r_cfg_height;
    t_setup_state        r_state, n_state;
    logic [AREA_W-1:0]   r_area;
    logic [AREA_W+4:0]   r_area19;

    logic                w_start;
    logic                w_running;
    logic [DIM_W-1:0]    w_width;
    logic [DIM_W-1:0]    w_height;
    logic                w_w_done, w_h_done;
    logic [TS_W-1:0]     w_tile_w, w_tile_h;
    logic [TI_W-1:0]     w_ncol, w_nrow;
    logic [2*TS_W-1:0]   w_area_full;

    logic                w_accept;
    logic                w_front_push;
    logic [IDX_W-1:0]    w_front_tx, w_front_ty;
    t_pix_flags          w_front_flags;
    logic                w_mid_full, w_mid_empty;
    logic [MID_W-1:0]    w_mid_out;
    logic                w_take;

    logic                       w_out_push;
    logic [TILE_FIELD_W-1:0]    w_res_row, w_res_col;
    logic                       w_res_fill, w_res_last;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_count;
    logic [OUT_W-1:0]           w_out_data;

    // Zero reads as one and anything above the largest image as the largest.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        if (v == 32'd0) begin
            v = 32'd1;
        end else if (v > 32'(MAX_DIM)) begin
            v = 32'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    assign w_width     = clamp_dim(r_cfg_width);
    assign w_height    = clamp_dim(r_cfg_height);
    assign w_area_full = {{TS_W{1'b0}}, w_tile_w} * {{TS_W{1'b0}}, w_tile_h};

    // Setup sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_START: n_state = S_SETUP;
            S_SETUP: begin
                if (w_w_done && w_h_done) begin
                    n_state = S_AREA;
                end
            end
            S_AREA:  n_state = S_SCALE;
            S_SCALE: n_state = S_RUN;
            S_RUN:   n_state = S_RUN;
            default: n_state = S_START;
        endcase
        if (i_cfg_we) begin
            n_state = S_START;
        end
    end

    // Setup sequencer: outputs.
    always_comb begin
        w_start   = 1'b0;
        w_running = 1'b0;
        case (r_state)
            S_START: w_start   = 1'b1;
            S_RUN:   w_running = 1'b1;
            default: begin
                w_start   = 1'b0;
                w_running = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_START;
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: begin
                        r_cfg_width <= r_cfg_width;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_AREA) begin
            r_area <= w_area_full[AREA_W-1:0];
        end
        if (r_state == S_SCALE) begin
            r_area19 <= {1'b0, r_area, 4'b0000} + {4'b0000, r_area, 1'b0}
                        + {5'b00000, r_area};
        end
    end

    tuc_dim_setup #(
        .GRID_TILES (GRID_TILES),
        .MAX_DIM    (MAX_DIM)
    ) u_setup_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dim   (w_width),
        .o_done  (w_w_done),
        .o_tile  (w_tile_w),
        .o_count (w_ncol)
    );

    tuc_dim_setup #(
        .GRID_TILES (GRID_TILES),
        .MAX_DIM    (MAX_DIM)
    ) u_setup_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dim   (w_height),
        .o_done  (w_h_done),
        .o_tile  (w_tile_h),
        .o_count (w_nrow)
    );

    assign full     = !w_running || w_mid_full;
    assign w_accept = push && !full;

    tuc_front #(
        .GRID_TILES (GRID_TILES),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_accept (w_accept),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_width  (w_width),
        .i_height (w_height),
        .i_tile_w (w_tile_w),
        .i_tile_h (w_tile_h),
        .i_ncol   (w_ncol),
        .i_nrow   (w_nrow),
        .o_push   (w_front_push),
        .o_tx     (w_front_tx),
        .o_ty     (w_front_ty),
        .o_flags  (w_front_flags)
    );

    tuc_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (w_front_push),
        .i_data  ({w_front_tx, w_front_ty, w_front_flags}),
        .i_pop   (w_take),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty),
        .o_count (),
        .o_data  (w_mid_out)
    );

    tuc_back #(
        .GRID_TILES (GRID_TILES),
        .MAX_DIM    (MAX_DIM),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_we),
        .i_valid      (!w_mid_empty),
        .i_tx         (w_mid_out[MID_W-1 -: IDX_W]),
        .i_ty         (w_mid_out[FLAG_W +: IDX_W]),
        .i_flags      (t_pix_flags'(w_mid_out[FLAG_W-1:0])),
        .o_take       (w_take),
        .i_out_count  (w_out_count),
        .i_area       (r_area),
        .i_area19     (r_area19),
        .o_push       (w_out_push),
        .o_tile_row   (w_res_row),
        .o_tile_col   (w_res_col),
        .o_make_white (w_res_fill),
        .o_last_tile  (w_res_last)
    );

    tuc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (w_out_push),
        .i_data  ({w_res_row, w_res_col, w_res_fill, w_res_last}),
        .i_pop   (pop),
        .o_full  (),
        .o_empty (empty),
        .o_count (w_out_count),
        .o_data  (w_out_data)
    );

    assign o_tile_row   = w_out_data[OUT_W-1 -: TILE_FIELD_W];
    assign o_tile_col   = w_out_data[2 +: TILE_FIELD_W];
    assign o_make_white = w_out_data[1];
    assign o_last_tile  = w_out_data[0];

    a_write_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> full)
        else $error("pixel input open right after a register write");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tile_uniformity_classifier_unit. Pixel beats are
// streamed through the push/full side from a backlog filled by the stimulus
// process. A bit-accurate predictor tracks the raster position and the
// white tallies, and the decision beats taken off the pop/empty side are
// checked field by field in order. Image sizes change between phases, with
// small images for most of the run and a few phases at the size limits.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tuc_pkg::*;

    localparam int GRID          = 10;
    localparam int DIM_CAP       = 4096;
    localparam int RANDOM_PIXELS = 1000;
    localparam int TAIL_CYCLES   = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 28;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [TILE_FIELD_W-1:0] row;
        logic [TILE_FIELD_W-1:0] col;
        logic                    make_white;
        logic                    last_tile;
    } t_verdict;

    // Tiles of one pixel on a 10x10 image, then tiles of two pixels on 20x10.
    localparam logic [23:0] AREA_ONE_PIXELS [12] = '{
        24'hFFFFFF, 24'h000000, 24'hFEFFFF, 24'hFFFEFF, 24'hFFFFFE, 24'hFFFFFF,
        24'h7F8001, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hAA55FF
    };
    localparam logic [23:0] AREA_TWO_PIXELS [12] = '{
        24'hFFFFFF, 24'hFFFF00, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h808080,
        24'hFF00FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF7FFF, 24'h000000, 24'h010101
    };
    localparam int WHITE_MIX [9] = '{0, 3, 5, 8, 50, 92, 95, 97, 100};

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [PIX_W-1:0]        i_red = '0;
    logic [PIX_W-1:0]        i_green = '0;
    logic [PIX_W-1:0]        i_blue = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [TILE_FIELD_W-1:0] o_tile_row;
    logic [TILE_FIELD_W-1:0] o_tile_col;
    logic                    o_make_white;
    logic                    o_last_tile;
    logic                    i_cfg_we = 1'b0;
    t_cfg_reg                i_cfg_idx = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    t_pixel   pixel_backlog [$];
    t_verdict verdicts_due [$];
    bit       steady = 1'b0;
    int       errors = 0;
    int       cycles = 0;

    // Predictor state: registers, per-column white tallies, raster position.
    logic [CFG_W-1:0] img_w;
    logic [CFG_W-1:0] img_h;
    int unsigned      white_tally [GRID];
    int unsigned      pos_x;
    int unsigned      pos_y;

    tile_uniformity_classifier_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .empty        (empty),
        .pop          (pop),
        .o_tile_row   (o_tile_row),
        .o_tile_col   (o_tile_col),
        .o_make_white (o_make_white),
        .o_last_tile  (o_last_tile),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned usable_dim(input int unsigned d);
        if (d == 0) return 1;
        if (d > DIM_CAP) return DIM_CAP;
        return d;
    endfunction

    function automatic int unsigned judged_tiles(input int unsigned d, input int unsigned t);
        int unsigned n;
        if (t == 0) return 0;
        n = (d - 1) / t;
        return (n > GRID) ? GRID : n;
    endfunction

    function automatic void restart_image();
        foreach (white_tally[i]) white_tally[i] = 0;
        pos_x = 0;
        pos_y = 0;
    endfunction

    // Advances the raster position by one pixel; returns 1 with the decision
    // when the pixel closes a judged tile.
    function automatic bit classify_pixel(input t_pixel p, output t_verdict v);
        int unsigned    w, h, tw, th, ncol, nrow, tx, ty;
        longint unsigned area, tally;
        bit             hit;
        w    = usable_dim(img_w);
        h    = usable_dim(img_h);
        tw   = w / GRID;
        th   = h / GRID;
        ncol = judged_tiles(w, tw);
        nrow = judged_tiles(h, th);
        hit  = 1'b0;
        v    = '0;
        if (ncol > 0 && nrow > 0) begin
            tx = pos_x / tw;
            ty = pos_y / th;
            if (tx < ncol && ty < nrow) begin
                if (p.red == PIX_FULL && p.green == PIX_FULL && p.blue == PIX_FULL)
                    white_tally[tx]++;
                if (pos_x == (tx + 1) * tw - 1 && pos_y == (ty + 1) * th - 1) begin
                    area  = tw * th;
                    tally = white_tally[tx];
                    v.row = TILE_FIELD_W'(ty);
                    v.col = TILE_FIELD_W'(tx);
                    v.make_white = (20 * tally > 19 * area) || (20 * tally <= area);
                    v.last_tile  = (tx == ncol - 1) && (ty == nrow - 1);
                    white_tally[tx] = 0;
                    hit = 1'b1;
                end
            end
        end
        if (pos_x + 1 >= w) begin
            pos_x = 0;
            pos_y = (pos_y + 1 >= h) ? 0 : pos_y + 1;
        end else begin
            pos_x = pos_x + 1;
        end
        return hit;
    endfunction

    function automatic t_pixel random_pixel(input int white_pct);
        t_pixel     p;
        logic [7:0] dip;
        if ($urandom_range(99) < white_pct) return '1;
        p = 24'($urandom);
        // A quarter of the non-white pixels miss white in one channel only.
        if ($urandom_range(3) == 0) begin
            p   = '1;
            dip = 8'($urandom_range(254));
            case ($urandom_range(2))
                0: p.red = dip;
                1: p.green = dip;
                default: p.blue = dip;
            endcase
        end
        return p;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Returns once no pixel is pending and every decision has been taken.
    task automatic settle();
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || push || verdicts_due.size() != 0);
    endtask

    task automatic write_dim(input t_cfg_reg sel, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= CFG_W'(value);
        if (sel == REG_IMAGE_WIDTH) img_w = CFG_W'(value);
        else img_h = CFG_W'(value);
        restart_image();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic reconfigure(input int unsigned w, input int unsigned h, input bit both);
        bit did_w;
        settle();
        // Pixels that close no tile may still be in flight.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        did_w = 1'b0;
        if (both || w != img_w || $urandom_range(1) == 1) begin
            write_dim(REG_IMAGE_WIDTH, w);
            did_w = 1'b1;
        end
        if (both || !did_w || h != img_h || $urandom_range(1) == 1)
            write_dim(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic feed(input int unsigned count, input int white_pct, input bit pause_midway);
        for (int unsigned i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) settle();
            pixel_backlog.push_back(random_pixel(white_pct));
        end
    endtask

    always @(posedge i_clk) begin : pixel_driver
        t_pixel   cur;
        t_pixel   nxt;
        t_verdict v;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                cur = {i_red, i_green, i_blue};
                if (classify_pixel(cur, v)) verdicts_due.push_back(v);
            end
            if (!push || !full) begin
                if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt     = pixel_backlog.pop_front();
                    push    <= 1'b1;
                    i_red   <= nxt.red;
                    i_green <= nxt.green;
                    i_blue  <= nxt.blue;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : verdict_monitor
        t_verdict want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (verdicts_due.size() == 0) begin
                    flag_error($sformatf("unexpected decision beat for tile %0d,%0d",
                                         o_tile_row, o_tile_col));
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("tile_row", o_tile_row, want.row);
                    check_field("tile_col", o_tile_col, want.col);
                    check_field("make_white", o_make_white, want.make_white);
                    check_field("last_tile", o_last_tile, want.last_tile);
                end
            end
            pop <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** tile_uniformity_classifier_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned w, h, n, count, counted;
        int          phase, pct;
        img_w = WIDTH_RESET;
        img_h = HEIGHT_RESET;
        restart_image();
        counted = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few beats at the reset size; no tile closes this early.
        feed(30, 50, 1'b0);

        reconfigure(10, 10, 1'b1);
        foreach (AREA_ONE_PIXELS[i]) pixel_backlog.push_back(t_pixel'(AREA_ONE_PIXELS[i]));
        reconfigure(20, 10, 1'b0);
        foreach (AREA_TWO_PIXELS[i]) pixel_backlog.push_back(t_pixel'(AREA_TWO_PIXELS[i]));

        phase = 0;
        while (counted < RANDOM_PIXELS || phase <= 8) begin
            pct = WHITE_MIX[$urandom_range(8)];
            case (phase)
                2: begin
                    // Width above the cap is clamped; the first one-line tile
                    // closes once a full clamped tile width has passed.
                    reconfigure(8191, 10, 1'b1);
                    feed(DIM_CAP / GRID + 20, pct, 1'b0);
                end
                4: begin
                    reconfigure(10, 8191, 1'b1);
                    feed(60, pct, 1'b0);
                end
                6: begin
                    reconfigure(0, 8191, 1'b1);
                    feed(60, pct, 1'b0);
                end
                8: begin
                    reconfigure(4096, 0, 1'b1);
                    feed(60, pct, 1'b0);
                end
                default: begin
                    w = $urandom_range(24, 10);
                    h = $urandom_range(16, 10);
                    if ($urandom_range(9) == 0) begin
                        if ($urandom_range(1) == 1) w = $urandom_range(9);
                        else h = $urandom_range(9);
                    end
                    n = usable_dim(w) * usable_dim(h);
                    count = $urandom_range(n + n / 2, n / 2);
                    reconfigure(w, h, 1'b0);
                    if (phase == 1) begin
                        steady = 1'b1;
                        feed(count, pct, 1'b0);
                        settle();
                        steady = 1'b0;
                    end else begin
                        feed(count, pct, phase == 0 || $urandom_range(4) == 0);
                    end
                    if (w >= GRID && h >= GRID) counted += count;
                end
            endcase
            phase++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdicts_due.size() != 0)
            flag_error($sformatf("%0d decisions never arrived", verdicts_due.size()));
        if (errors == 0) begin
            $display("** tile_uniformity_classifier_unit: PASSED **");
        end else begin
            $display("** tile_uniformity_classifier_unit: FAILED **");
        end
        $finish;
    end

endmodule
